@@ rtl/hsv2rgb_pkg.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types and constants for the HSV to RGB colour converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;

   localparam int HUE_MAX = 360;
   localparam int PCT_MAX = 100;

   typedef enum logic [2:0] {
      SEC_RED_YEL,
      SEC_YEL_GRN,
      SEC_GRN_CYN,
      SEC_CYN_BLU,
      SEC_BLU_MAG,
      SEC_MAG_RED
   } sector_type;

   typedef struct packed {
      logic [8:0] hue_degrees;
      logic [6:0] saturation_pct;
      logic [6:0] value_pct;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       in_range;
   } rsp_type;

endpackage

@@ rtl/hsv_to_rgb_converter.sv @@
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Five-stage pipelined HSV to 8-bit RGB conversion in unsigned fixed point.
// ----------------------------------------------------------------------------
// A request is taken on every clock in which start is high; busy is always
// low. Its result appears on rsp_data with rsp_valid high for one cycle,
// and results leave in request order. The result passes through five
// register stages: sector decode, percent and hue-ramp lookup, chroma
// multiply, secondary multiply, channel scaling.
// The receiver cannot stall, so nothing holds the pipeline back.
module hsv_to_rgb_converter #(
   parameter int FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  hsv2rgb_pkg::req_type req_data,
   output logic                 rsp_valid,
   output hsv2rgb_pkg::rsp_type rsp_data
);

   localparam int FW = FRAC_BITS + 1;

   // constant tables
   logic [FW-1:0] pct_tab [128];
   logic [FW-1:0] ramp_tab [64];

   for (genvar g = 0; g < 128; g++) begin : g_pct
      localparam logic [63:0] PV =
         (g <= hsv2rgb_pkg::PCT_MAX) ? ((64'(g) << FRAC_BITS) / 64'd100) : 64'd0;
      assign pct_tab[g] = PV[FW-1:0];
   end

   for (genvar g = 0; g < 64; g++) begin : g_ramp
      localparam logic [63:0] KV = (g <= 60) ? ((64'(g) << FRAC_BITS) / 64'd60) : 64'd0;
      assign ramp_tab[g] = KV[FW-1:0];
   end

   function automatic logic [7:0] chan_scale(input logic [FW-1:0] part,
                                             input logic [FW-1:0] offs);
      logic [FW:0]   sum;
      logic [FW+8:0] scaled;
      begin
         sum    = {1'b0, part} + {1'b0, offs};
         scaled = {sum, 8'd0} - {8'd0, sum};
         if (|scaled[FW+8:FRAC_BITS+8]) begin
            chan_scale = 8'hFF;
         end else begin
            chan_scale = scaled[FRAC_BITS+7:FRAC_BITS];
         end
      end
   endfunction

   assign busy = 1'b0;

   // stage 1: range check, sector and hue ramp index
   logic                   valid1_ff, valid1_in;
   logic                   ok1_ff, ok1_in;
   hsv2rgb_pkg::sector_type sec1_ff, sec1_in;
   logic [5:0]             kidx1_ff, kidx1_in;
   logic [6:0]             sat1_ff, val1_ff;

   logic [8:0] hue;
   logic [8:0] tmod;
   logic [8:0] ramp_dev;
   logic [8:0] kfull;

   always_comb begin
      hue       = req_data.hue_degrees;
      valid1_in = start;
      ok1_in    = (hue <= 9'(hsv2rgb_pkg::HUE_MAX))
               && (req_data.saturation_pct <= 7'(hsv2rgb_pkg::PCT_MAX))
               && (req_data.value_pct <= 7'(hsv2rgb_pkg::PCT_MAX));
      priority if (hue < 9'd60) begin
         sec1_in = hsv2rgb_pkg::SEC_RED_YEL;
      end else if (hue < 9'd120) begin
         sec1_in = hsv2rgb_pkg::SEC_YEL_GRN;
      end else if (hue < 9'd180) begin
         sec1_in = hsv2rgb_pkg::SEC_GRN_CYN;
      end else if (hue < 9'd240) begin
         sec1_in = hsv2rgb_pkg::SEC_CYN_BLU;
      end else if (hue < 9'd300) begin
         sec1_in = hsv2rgb_pkg::SEC_BLU_MAG;
      end else begin
         sec1_in = hsv2rgb_pkg::SEC_MAG_RED;
      end
      priority if (hue < 9'd120) begin
         tmod = hue;
      end else if (hue < 9'd240) begin
         tmod = hue - 9'd120;
      end else if (hue < 9'd360) begin
         tmod = hue - 9'd240;
      end else begin
         tmod = hue - 9'd360;
      end
      ramp_dev = (tmod >= 9'd60) ? (tmod - 9'd60) : (9'd60 - tmod);
      kfull    = 9'd60 - ramp_dev;
      kidx1_in = kfull[5:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= valid1_in;
      end
      ok1_ff   <= ok1_in;
      sec1_ff  <= sec1_in;
      kidx1_ff <= kidx1_in;
      sat1_ff  <= req_data.saturation_pct;
      val1_ff  <= req_data.value_pct;
   end

   // stage 2: table lookups
   logic                   valid2_ff;
   logic                   ok2_ff;
   hsv2rgb_pkg::sector_type sec2_ff;
   logic [FW-1:0]          sf2_ff, sf2_in;
   logic [FW-1:0]          vf2_ff, vf2_in;
   logic [FW-1:0]          kf2_ff, kf2_in;

   always_comb begin
      sf2_in = pct_tab[sat1_ff];
      vf2_in = pct_tab[val1_ff];
      kf2_in = ramp_tab[kidx1_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else begin
         valid2_ff <= valid1_ff;
      end
      ok2_ff  <= ok1_ff;
      sec2_ff <= sec1_ff;
      sf2_ff  <= sf2_in;
      vf2_ff  <= vf2_in;
      kf2_ff  <= kf2_in;
   end

   // stage 3: chroma
   logic                   valid3_ff;
   logic                   ok3_ff;
   hsv2rgb_pkg::sector_type sec3_ff;
   logic [FW-1:0]          cf3_ff, cf3_in;
   logic [FW-1:0]          vf3_ff;
   logic [FW-1:0]          kf3_ff;
   logic [2*FW-1:0]        chroma_prod;

   always_comb begin
      chroma_prod = {{FW{1'b0}}, sf2_ff} * {{FW{1'b0}}, vf2_ff};
      cf3_in      = chroma_prod[FRAC_BITS +: FW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
      end else begin
         valid3_ff <= valid2_ff;
      end
      ok3_ff  <= ok2_ff;
      sec3_ff <= sec2_ff;
      cf3_ff  <= cf3_in;
      vf3_ff  <= vf2_ff;
      kf3_ff  <= kf2_ff;
   end

   // stage 4: secondary component and offset
   logic                   valid4_ff;
   logic                   ok4_ff;
   hsv2rgb_pkg::sector_type sec4_ff;
   logic [FW-1:0]          cf4_ff;
   logic [FW-1:0]          xf4_ff, xf4_in;
   logic [FW-1:0]          mf4_ff, mf4_in;
   logic [2*FW-1:0]        second_prod;

   always_comb begin
      second_prod = {{FW{1'b0}}, cf3_ff} * {{FW{1'b0}}, kf3_ff};
      xf4_in      = second_prod[FRAC_BITS +: FW];
      mf4_in      = (vf3_ff >= cf3_ff) ? (vf3_ff - cf3_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid4_ff <= 1'b0;
      end else begin
         valid4_ff <= valid3_ff;
      end
      ok4_ff  <= ok3_ff;
      sec4_ff <= sec3_ff;
      cf4_ff  <= cf3_ff;
      xf4_ff  <= xf4_in;
      mf4_ff  <= mf4_in;
   end

   // stage 5: channel ordering and scaling
   logic                 valid5_ff;
   hsv2rgb_pkg::rsp_type rsp_ff, rsp_in;
   logic [FW-1:0]        red_part, green_part, blue_part;

   always_comb begin
      unique case (sec4_ff)
         hsv2rgb_pkg::SEC_RED_YEL: begin
            red_part = cf4_ff; green_part = xf4_ff; blue_part = '0;
         end
         hsv2rgb_pkg::SEC_YEL_GRN: begin
            red_part = xf4_ff; green_part = cf4_ff; blue_part = '0;
         end
         hsv2rgb_pkg::SEC_GRN_CYN: begin
            red_part = '0; green_part = cf4_ff; blue_part = xf4_ff;
         end
         hsv2rgb_pkg::SEC_CYN_BLU: begin
            red_part = '0; green_part = xf4_ff; blue_part = cf4_ff;
         end
         hsv2rgb_pkg::SEC_BLU_MAG: begin
            red_part = xf4_ff; green_part = '0; blue_part = cf4_ff;
         end
         default: begin
            red_part = cf4_ff; green_part = '0; blue_part = xf4_ff;
         end
      endcase
      if (ok4_ff) begin
         rsp_in.red      = chan_scale(red_part, mf4_ff);
         rsp_in.green    = chan_scale(green_part, mf4_ff);
         rsp_in.blue     = chan_scale(blue_part, mf4_ff);
         rsp_in.in_range = 1'b1;
      end else begin
         rsp_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid5_ff <= 1'b0;
      end else begin
         valid5_ff <= valid4_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid5_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks hsv_to_rgb_converter against its own fixed-point colour predictor.
// Directed corner colours come first, then random requests; idle cycles are
// put in bursts on the request side while more than 120 requests wait. Every
// result is compared with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int FRAC        = hsv2rgb_pkg::FRAC_BITS_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;

   logic                 clock    = 1'b0;
   logic                 reset    = 1'b1;
   logic                 start    = 1'b0;
   hsv2rgb_pkg::req_type req_data = '0;
   logic                 busy;
   logic                 rsp_valid;
   hsv2rgb_pkg::rsp_type rsp_data;

   hsv2rgb_pkg::req_type pending_hsv[$];
   hsv2rgb_pkg::rsp_type expected_rgb[$];
   int      request_total  = 0;
   int      accepted_count = 0;
   int      mismatch_count = 0;
   int      cycle_count    = 0;
   int      gap_left       = 0;

   hsv_to_rgb_converter #(.FRAC_BITS(FRAC)) uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [7:0] scale_channel(longint unsigned part, longint unsigned offs);
      longint unsigned level;
      level = (64'd255 * (part + offs)) >> FRAC;
      return (level > 255) ? 8'd255 : level[7:0];
   endfunction

   function automatic hsv2rgb_pkg::rsp_type rgb_of(hsv2rgb_pkg::req_type hsv);
      longint unsigned         one_fx, h, s, v, sf, vf, cf, kf, xf, mf, t, d;
      longint unsigned         r, g, b;
      hsv2rgb_pkg::sector_type sector;
      hsv2rgb_pkg::rsp_type    rgb;
      one_fx = 64'd1 << FRAC;
      h = hsv.hue_degrees;
      s = hsv.saturation_pct;
      v = hsv.value_pct;
      rgb = '0;
      if (h > hsv2rgb_pkg::HUE_MAX || s > hsv2rgb_pkg::PCT_MAX
          || v > hsv2rgb_pkg::PCT_MAX) begin
         return rgb;
      end
      sf = (s * one_fx) / hsv2rgb_pkg::PCT_MAX;
      vf = (v * one_fx) / hsv2rgb_pkg::PCT_MAX;
      cf = (sf * vf) >> FRAC;
      t  = h % 120;
      d  = (t >= 60) ? (t - 60) : (60 - t);
      kf = ((60 - d) * one_fx) / 60;
      xf = (cf * kf) >> FRAC;
      mf = (vf >= cf) ? (vf - cf) : 0;
      // hue of 360 stays in the magenta-red sector
      sector = (h >= 300) ? hsv2rgb_pkg::SEC_MAG_RED : hsv2rgb_pkg::sector_type'(h / 60);
      case (sector)
         hsv2rgb_pkg::SEC_RED_YEL: begin r = cf; g = xf; b = 0;  end
         hsv2rgb_pkg::SEC_YEL_GRN: begin r = xf; g = cf; b = 0;  end
         hsv2rgb_pkg::SEC_GRN_CYN: begin r = 0;  g = cf; b = xf; end
         hsv2rgb_pkg::SEC_CYN_BLU: begin r = 0;  g = xf; b = cf; end
         hsv2rgb_pkg::SEC_BLU_MAG: begin r = xf; g = 0;  b = cf; end
         default: begin r = cf; g = 0;  b = xf; end
      endcase
      rgb.red      = scale_channel(r, mf);
      rgb.green    = scale_channel(g, mf);
      rgb.blue     = scale_channel(b, mf);
      rgb.in_range = 1'b1;
      return rgb;
   endfunction

   function automatic void queue_hsv(int h, int s, int v);
      hsv2rgb_pkg::req_type hsv;
      hsv.hue_degrees    = h[8:0];
      hsv.saturation_pct = s[6:0];
      hsv.value_pct      = v[6:0];
      pending_hsv.push_back(hsv);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_rgb.push_back(rgb_of(req_data));
            accepted_count++;
         end
         if (start && busy) begin
            start <= 1'b1;
         end else if (gap_left > 0) begin
            start <= 1'b0;
            gap_left--;
         end else if (pending_hsv.size() > 0) begin
            if (pending_hsv.size() > 120 && $urandom_range(0, 4) == 0) begin
               start    <= 1'b0;
               gap_left = $urandom_range(0, 2);
            end else begin
               start    <= 1'b1;
               req_data <= pending_hsv.pop_front();
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      hsv2rgb_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rgb.size() == 0) begin
            $error("unexpected result: red %0d green %0d blue %0d in_range %0d",
                   rsp_data.red, rsp_data.green, rsp_data.blue, rsp_data.in_range);
            mismatch_count++;
         end else begin
            want = expected_rgb.pop_front();
            if (rsp_data.red !== want.red) begin
               $error("red: expected %0d, got %0d", want.red, rsp_data.red);
               mismatch_count++;
            end
            if (rsp_data.green !== want.green) begin
               $error("green: expected %0d, got %0d", want.green, rsp_data.green);
               mismatch_count++;
            end
            if (rsp_data.blue !== want.blue) begin
               $error("blue: expected %0d, got %0d", want.blue, rsp_data.blue);
               mismatch_count++;
            end
            if (rsp_data.in_range !== want.in_range) begin
               $error("in_range: expected %0d, got %0d", want.in_range, rsp_data.in_range);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int hues[13];
      int pick;
      hues = '{0, 59, 60, 61, 119, 120, 180, 240, 300, 359, 360, 361, 511};
      foreach (hues[i]) begin
         queue_hsv(hues[i], 100, 100);
      end
      queue_hsv(90, 0, 100);
      queue_hsv(90, 100, 0);
      queue_hsv(0, 0, 0);
      queue_hsv(200, 101, 50);
      queue_hsv(200, 50, 101);
      queue_hsv(200, 127, 127);
      queue_hsv(360, 50, 75);
      queue_hsv(511, 127, 127);
      queue_hsv(30, 1, 1);
      queue_hsv(330, 99, 99);
      for (int i = 0; i < 900; i++) begin
         pick = $urandom_range(0, 9);
         if (pick < 2) begin
            queue_hsv($urandom_range(0, 511), $urandom_range(0, 127), $urandom_range(0, 127));
         end else begin
            queue_hsv($urandom_range(0, hsv2rgb_pkg::HUE_MAX),
                      $urandom_range(0, hsv2rgb_pkg::PCT_MAX),
                      $urandom_range(0, hsv2rgb_pkg::PCT_MAX));
         end
      end
      request_total = pending_hsv.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      wait (accepted_count == request_total);
      while (expected_rgb.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
